>>> design/terminal_line_discipline_macros.svh
// Assertion macros for the terminal line discipline.
`ifndef TERMINAL_LINE_DISCIPLINE_MACROS_SVH
`define TERMINAL_LINE_DISCIPLINE_MACROS_SVH

// Check that cons holds in the cycle in which ante holds.
`define TLD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("terminal line discipline: same-cycle check failed");

// Check that cons holds in the cycle after ante holds.
`define TLD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("terminal line discipline: next-cycle check failed");

`endif

>>> design/tld_pkg.sv
// Types, codes and constants of the terminal line discipline.
`timescale 1ns / 1ps
package tld_pkg;

    localparam int RING_DEPTH_DEF = 1024;
    localparam int LINE_DEPTH_DEF = 1024;
    localparam int CFG_AW         = 5;

    localparam logic [1:0] OP_MASTER_WRITE = 2'd0;
    localparam logic [1:0] OP_SLAVE_WRITE  = 2'd1;
    localparam logic [1:0] OP_SLAVE_READ   = 2'd2;
    localparam logic [1:0] OP_MASTER_READ  = 2'd3;

    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_EOF   = 2'd2;

    localparam logic [2:0] REG_CANON  = 3'd0;
    localparam logic [2:0] REG_ECHO   = 3'd1;
    localparam logic [2:0] REG_SIG    = 3'd2;
    localparam logic [2:0] REG_INTR   = 3'd3;
    localparam logic [2:0] REG_EOF    = 3'd4;
    localparam logic [2:0] REG_ERASE  = 3'd5;
    localparam logic [2:0] REG_KILL   = 3'd6;
    localparam logic [2:0] REG_TARGET = 3'd7;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam logic [7:0] RST_INTR  = 8'd3;
    localparam logic [7:0] RST_EOF   = 8'd4;
    localparam logic [7:0] RST_ERASE = 8'd8;
    localparam logic [7:0] RST_KILL  = 8'd21;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ECHO,
        S_FLUSH_RD,
        S_FLUSH_WR,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        E_CHAR,
        E_INTR,
        E_RUB
    } t_echo;

    function automatic logic [7:0] echo_char(input t_echo kind, input logic [1:0] idx,
                                             input logic [7:0] c);
        logic [7:0] b;
        b = c;
        unique case (kind)
            E_CHAR: b = c;
            E_INTR: b = (idx == 2'd0) ? CH_CARET : ((idx == 2'd1) ? CH_C : CH_NL);
            E_RUB:  b = (idx == 2'd1) ? CH_SP : CH_BS;
            default: b = c;
        endcase
        return b;
    endfunction

endpackage

>>> design/terminal_line_discipline.sv
// Top level of the terminal line discipline: sequencer, ring memory and line memory.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+-------------------------------
//  request  | in        | i_s_tvalid / o_s_tready      | i_s_tdata, i_s_tuser
//  result   | out       | o_m_tvalid / i_m_tready      | o_m_tdata, o_m_tuser
//  config   | in        | i_psel, i_penable, i_pwrite  | i_paddr, i_pwdata, o_prdata
//
// One request at a time. Kill rubs out one character per echo pass; a commit copies each
// byte from the line memory through the single ring write port. Reset clears pointers, line
// length and end-of-file; memory contents stay as they are. A stalled result holds the next
// request off.
`timescale 1ns / 1ps
`include "terminal_line_discipline_macros.svh"
module terminal_line_discipline #(
    parameter int RING_DEPTH = tld_pkg::RING_DEPTH_DEF,
    parameter int LINE_DEPTH = tld_pkg::LINE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [7:0]                i_s_tdata,   // data[7:0]
    input  logic [1:0]                i_s_tuser,   // op[1:0]
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // accepted[0], read_byte[8:1], raise_interrupt[9], lost_bytes[19:10],
    // slave_readable[20], master_readable[21], master_writable[22], slave_writable[23]
    output logic [23:0]               o_m_tdata,
    output logic [1:0]                o_m_tuser,   // read_status[1:0]
    input  logic                      i_psel,
    input  logic                      i_penable,
    input  logic                      i_pwrite,
    input  logic [tld_pkg::CFG_AW-1:0] i_paddr,
    input  logic [31:0]               i_pwdata,
    output logic [31:0]               o_prdata,
    output logic                      o_pready
);

    localparam int RW = $clog2(RING_DEPTH);
    localparam int LW = $clog2(LINE_DEPTH);

    tld_pkg::t_state r_state, n_state;
    tld_pkg::t_echo  r_echo_kind, n_echo_kind;

    logic          r_canon, r_echo_en, r_sig_en, r_target;
    logic [7:0]    r_intr, r_eofc, r_erase, r_kill_c;

    logic [RW-1:0] r_ihead, n_ihead, r_itail, n_itail, r_ohead, n_ohead, r_otail, n_otail;
    logic [LW-1:0] r_line_len, n_line_len, r_took, n_took;
    logic          r_eof, n_eof;
    logic [1:0]    r_op, n_op;
    logic [7:0]    r_data, n_data;
    logic [1:0]    r_echo_idx, n_echo_idx;
    logic          r_kill, n_kill, r_commit, n_commit;
    logic          r_acc, n_acc, r_raise, n_raise, r_rd_ok, n_rd_ok;
    logic [1:0]    r_status, n_status;
    logic [9:0]    r_lost, n_lost;
    logic          r_out_valid, n_out_valid;
    logic [23:0]   r_out_data, n_out_data;
    logic [1:0]    r_out_user, n_out_user;

    logic [7:0]    r_ring [2][RING_DEPTH];
    logic [7:0]    r_ring_q;
    logic [7:0]    r_line [LINE_DEPTH];
    logic [7:0]    r_line_q;

    logic          ring_we, ring_wsel, ring_re, ring_rsel;
    logic [RW-1:0] ring_wptr, ring_rptr;
    logic [7:0]    ring_wdata;
    logic          line_we, line_re;
    logic [LW-1:0] line_waddr, line_raddr;
    logic [7:0]    line_wdata;

    logic          in_room, out_room, in_empty, out_empty, cfg_we;
    logic [LW-1:0] diff;

    function automatic logic [RW-1:0] ptr_inc(input logic [RW-1:0] p);
        return (p == RW'(RING_DEPTH - 1)) ? '0 : p + RW'(1);
    endfunction

    function automatic logic [RW-1:0] ring_cnt(input logic [RW-1:0] h, input logic [RW-1:0] t);
        logic [RW:0] s;
        s = {1'b0, h} + (RW + 1)'(RING_DEPTH) - {1'b0, t};
        return (h >= t) ? (h - t) : s[RW-1:0];
    endfunction

    assign in_room   = ring_cnt(r_ihead, r_itail) < RW'(RING_DEPTH - 1);
    assign out_room  = ring_cnt(r_ohead, r_otail) < RW'(RING_DEPTH - 1);
    assign in_empty  = (r_ihead == r_itail);
    assign out_empty = (r_ohead == r_otail);
    assign diff      = r_line_len - r_took;

    assign o_s_tready = (r_state == tld_pkg::S_IDLE) && (!r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign o_pready   = 1'b1;
    assign cfg_we     = i_psel && i_penable && i_pwrite;

    always_comb begin
        o_prdata = '0;
        unique case (i_paddr[4:2])
            tld_pkg::REG_CANON:  o_prdata = {31'd0, r_canon};
            tld_pkg::REG_ECHO:   o_prdata = {31'd0, r_echo_en};
            tld_pkg::REG_SIG:    o_prdata = {31'd0, r_sig_en};
            tld_pkg::REG_INTR:   o_prdata = {24'd0, r_intr};
            tld_pkg::REG_EOF:    o_prdata = {24'd0, r_eofc};
            tld_pkg::REG_ERASE:  o_prdata = {24'd0, r_erase};
            tld_pkg::REG_KILL:   o_prdata = {24'd0, r_kill_c};
            tld_pkg::REG_TARGET: o_prdata = {31'd0, r_target};
            default:             o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canon   <= 1'b1;
            r_echo_en <= 1'b1;
            r_sig_en  <= 1'b1;
            r_target  <= 1'b1;
            r_intr    <= tld_pkg::RST_INTR;
            r_eofc    <= tld_pkg::RST_EOF;
            r_erase   <= tld_pkg::RST_ERASE;
            r_kill_c  <= tld_pkg::RST_KILL;
        end else if (cfg_we) begin
            unique case (i_paddr[4:2])
                tld_pkg::REG_CANON:  r_canon   <= i_pwdata[0];
                tld_pkg::REG_ECHO:   r_echo_en <= i_pwdata[0];
                tld_pkg::REG_SIG:    r_sig_en  <= i_pwdata[0];
                tld_pkg::REG_INTR:   r_intr    <= i_pwdata[7:0];
                tld_pkg::REG_EOF:    r_eofc    <= i_pwdata[7:0];
                tld_pkg::REG_ERASE:  r_erase   <= i_pwdata[7:0];
                tld_pkg::REG_KILL:   r_kill_c  <= i_pwdata[7:0];
                tld_pkg::REG_TARGET: r_target  <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[ring_wsel][ring_wptr] <= ring_wdata;
        end
        if (ring_re) begin
            r_ring_q <= r_ring[ring_rsel][ring_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (line_we) begin
            r_line[line_waddr] <= line_wdata;
        end
        if (line_re) begin
            r_line_q <= r_line[line_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tld_pkg::S_IDLE;
            r_ihead     <= '0;
            r_itail     <= '0;
            r_ohead     <= '0;
            r_otail     <= '0;
            r_line_len  <= '0;
            r_eof       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ihead     <= n_ihead;
            r_itail     <= n_itail;
            r_ohead     <= n_ohead;
            r_otail     <= n_otail;
            r_line_len  <= n_line_len;
            r_eof       <= n_eof;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_echo_kind <= n_echo_kind;
        r_took      <= n_took;
        r_op        <= n_op;
        r_data      <= n_data;
        r_echo_idx  <= n_echo_idx;
        r_kill      <= n_kill;
        r_commit    <= n_commit;
        r_acc       <= n_acc;
        r_raise     <= n_raise;
        r_rd_ok     <= n_rd_ok;
        r_status    <= n_status;
        r_lost      <= n_lost;
        r_out_data  <= n_out_data;
        r_out_user  <= n_out_user;
    end

    always_comb begin
        n_state     = r_state;
        n_echo_kind = r_echo_kind;
        n_ihead     = r_ihead;
        n_itail     = r_itail;
        n_ohead     = r_ohead;
        n_otail     = r_otail;
        n_line_len  = r_line_len;
        n_took      = r_took;
        n_eof       = r_eof;
        n_op        = r_op;
        n_data      = r_data;
        n_echo_idx  = r_echo_idx;
        n_kill      = r_kill;
        n_commit    = r_commit;
        n_acc       = r_acc;
        n_raise     = r_raise;
        n_rd_ok     = r_rd_ok;
        n_status    = r_status;
        n_lost      = r_lost;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        ring_we     = 1'b0;
        ring_wsel   = 1'b0;
        ring_wptr   = r_ihead;
        ring_wdata  = r_data;
        ring_re     = 1'b0;
        ring_rsel   = 1'b0;
        ring_rptr   = r_itail;
        line_we     = 1'b0;
        line_waddr  = r_line_len;
        line_wdata  = r_data;
        line_re     = 1'b0;
        line_raddr  = r_took;

        unique case (r_state)
            tld_pkg::S_IDLE: begin
                if (i_s_tvalid && o_s_tready) begin
                    n_op       = i_s_tuser;
                    n_data     = i_s_tdata;
                    n_acc      = 1'b0;
                    n_raise    = 1'b0;
                    n_rd_ok    = 1'b0;
                    n_status   = tld_pkg::ST_DATA;
                    n_lost     = '0;
                    n_kill     = 1'b0;
                    n_commit   = 1'b0;
                    n_echo_idx = '0;
                    n_state    = tld_pkg::S_EXEC;
                end
            end
            tld_pkg::S_EXEC: begin
                n_state = tld_pkg::S_FIN;
                unique case (r_op)
                    tld_pkg::OP_MASTER_WRITE: begin
                        if (r_sig_en && r_data == r_intr) begin
                            n_line_len  = '0;
                            n_acc       = 1'b1;
                            n_raise     = r_target;
                            n_echo_kind = tld_pkg::E_INTR;
                            n_state     = tld_pkg::S_ECHO;
                        end else if (!r_canon) begin
                            if (in_room) begin
                                ring_we     = 1'b1;
                                n_ihead     = ptr_inc(r_ihead);
                                n_acc       = 1'b1;
                                n_echo_kind = tld_pkg::E_CHAR;
                                n_state     = tld_pkg::S_ECHO;
                            end
                        end else if (r_data == r_erase || r_data == tld_pkg::CH_DEL) begin
                            n_acc = 1'b1;
                            if (r_line_len != '0) begin
                                n_line_len  = r_line_len - LW'(1);
                                n_echo_kind = tld_pkg::E_RUB;
                                n_state     = tld_pkg::S_ECHO;
                            end
                        end else if (r_data == r_kill_c) begin
                            n_acc = 1'b1;
                            if (r_line_len != '0) begin
                                n_line_len  = r_line_len - LW'(1);
                                n_kill      = 1'b1;
                                n_echo_kind = tld_pkg::E_RUB;
                                n_state     = tld_pkg::S_ECHO;
                            end
                        end else if (r_data == r_eofc) begin
                            n_acc = 1'b1;
                            if (r_line_len == '0) begin
                                n_eof = 1'b1;
                            end else begin
                                n_took  = '0;
                                n_state = tld_pkg::S_FLUSH_RD;
                            end
                        end else if (r_line_len < LW'(LINE_DEPTH - 1)) begin
                            line_we     = 1'b1;
                            n_line_len  = r_line_len + LW'(1);
                            n_acc       = 1'b1;
                            n_commit    = (r_data == tld_pkg::CH_NL);
                            n_echo_kind = tld_pkg::E_CHAR;
                            n_state     = tld_pkg::S_ECHO;
                        end
                    end
                    tld_pkg::OP_SLAVE_WRITE: begin
                        if (out_room) begin
                            ring_we   = 1'b1;
                            ring_wsel = 1'b1;
                            ring_wptr = r_ohead;
                            n_ohead   = ptr_inc(r_ohead);
                            n_acc     = 1'b1;
                        end
                    end
                    tld_pkg::OP_SLAVE_READ: begin
                        if (!in_empty) begin
                            ring_re = 1'b1;
                            n_itail = ptr_inc(r_itail);
                            n_rd_ok = 1'b1;
                        end else if (r_eof) begin
                            n_eof    = 1'b0;
                            n_status = tld_pkg::ST_EOF;
                        end else begin
                            n_status = tld_pkg::ST_EMPTY;
                        end
                    end
                    tld_pkg::OP_MASTER_READ: begin
                        if (!out_empty) begin
                            ring_re   = 1'b1;
                            ring_rsel = 1'b1;
                            ring_rptr = r_otail;
                            n_otail   = ptr_inc(r_otail);
                            n_rd_ok   = 1'b1;
                        end else begin
                            n_status = tld_pkg::ST_EMPTY;
                        end
                    end
                    default: ;
                endcase
            end
            tld_pkg::S_ECHO: begin
                if (r_echo_en && out_room) begin
                    ring_we    = 1'b1;
                    ring_wsel  = 1'b1;
                    ring_wptr  = r_ohead;
                    ring_wdata = tld_pkg::echo_char(r_echo_kind, r_echo_idx, r_data);
                    n_ohead    = ptr_inc(r_ohead);
                end
                n_echo_idx = r_echo_idx + 2'd1;
                if (r_echo_idx == ((r_echo_kind == tld_pkg::E_CHAR) ? 2'd0 : 2'd2)) begin
                    n_echo_idx = '0;
                    if (r_kill && r_line_len != '0) begin
                        n_line_len = r_line_len - LW'(1);
                    end else if (r_commit) begin
                        n_took  = '0;
                        n_state = tld_pkg::S_FLUSH_RD;
                    end else begin
                        n_state = tld_pkg::S_FIN;
                    end
                end
            end
            tld_pkg::S_FLUSH_RD: begin
                if (r_took < r_line_len && in_room) begin
                    line_re = 1'b1;
                    n_state = tld_pkg::S_FLUSH_WR;
                end else begin
                    n_lost     = (32'(diff) > 32'd1023) ? 10'd1023 : 10'(diff);
                    n_line_len = '0;
                    n_state    = tld_pkg::S_FIN;
                end
            end
            tld_pkg::S_FLUSH_WR: begin
                ring_we    = 1'b1;
                ring_wdata = r_line_q;
                n_ihead    = ptr_inc(r_ihead);
                n_took     = r_took + LW'(1);
                n_state    = tld_pkg::S_FLUSH_RD;
            end
            tld_pkg::S_FIN: begin
                n_out_valid = 1'b1;
                n_out_user  = r_status;
                n_out_data  = {out_room,
                               r_canon ? (r_line_len < LW'(LINE_DEPTH - 1)) : in_room,
                               !out_empty,
                               !in_empty || r_eof,
                               r_lost,
                               r_raise,
                               r_rd_ok ? r_ring_q : 8'd0,
                               r_acc};
                n_state     = tld_pkg::S_IDLE;
            end
            default: n_state = tld_pkg::S_IDLE;
        endcase
    end

    `TLD_ASSERT_NEXT(a_accept_starts_exec, i_s_tvalid && o_s_tready, r_state == tld_pkg::S_EXEC)
    `TLD_ASSERT_NEXT(a_fin_loads_result, r_state == tld_pkg::S_FIN, r_out_valid)
    `TLD_ASSERT_IMP(a_line_bound, r_state != tld_pkg::S_IDLE, r_line_len <= LW'(LINE_DEPTH - 1))
    `TLD_ASSERT_IMP(a_no_write_idle, ring_we, r_state != tld_pkg::S_IDLE && r_state != tld_pkg::S_FIN)

endmodule

>>> bench/tb.sv
// Self-checking testbench for the terminal line discipline: predictor, stream and APB drivers.
`timescale 1ns / 1ps
module tb;

    typedef struct packed {
        logic       accepted;
        logic [7:0] read_byte;
        logic [1:0] read_status;
        logic       raise_interrupt;
        logic [9:0] lost_bytes;
        logic       slave_readable;
        logic       master_readable;
        logic       master_writable;
        logic       slave_writable;
    } t_tty_result;

    class tty_scoreboard;
        localparam int RD = 1024;
        localparam int LD = 1024;
        logic [7:0] in_ring[RD];
        logic [7:0] out_ring[RD];
        logic [7:0] line_buf[LD];
        int in_head, in_tail, out_head, out_tail, line_len;
        bit eof_flag;
        bit canon, echo_on, sig_on, target_on;
        logic [7:0] intr_ch, eof_ch, erase_ch, kill_ch;
        t_tty_result pending[$];
        int mismatches, results_seen, requests_seen;

        function void init();
            in_head = 0; in_tail = 0; out_head = 0; out_tail = 0;
            line_len = 0; eof_flag = 0;
            canon = 1; echo_on = 1; sig_on = 1; target_on = 1;
            intr_ch = tld_pkg::RST_INTR; eof_ch = tld_pkg::RST_EOF;
            erase_ch = tld_pkg::RST_ERASE; kill_ch = tld_pkg::RST_KILL;
            mismatches = 0; results_seen = 0; requests_seen = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                tld_pkg::REG_CANON:  canon = val[0];
                tld_pkg::REG_ECHO:   echo_on = val[0];
                tld_pkg::REG_SIG:    sig_on = val[0];
                tld_pkg::REG_INTR:   intr_ch = val[7:0];
                tld_pkg::REG_EOF:    eof_ch = val[7:0];
                tld_pkg::REG_ERASE:  erase_ch = val[7:0];
                tld_pkg::REG_KILL:   kill_ch = val[7:0];
                tld_pkg::REG_TARGET: target_on = val[0];
                default: ;
            endcase
        endfunction

        function int in_count();
            return (in_head + RD - in_tail) % RD;
        endfunction

        function int out_count();
            return (out_head + RD - out_tail) % RD;
        endfunction

        function bit push_in(logic [7:0] b);
            if (in_count() >= RD - 1) return 0;
            in_ring[in_head] = b;
            in_head = (in_head + 1) % RD;
            return 1;
        endfunction

        function bit push_out(logic [7:0] b);
            if (out_count() >= RD - 1) return 0;
            out_ring[out_head] = b;
            out_head = (out_head + 1) % RD;
            return 1;
        endfunction

        function void echo(logic [7:0] b);
            bit ok;
            if (echo_on) ok = push_out(b);
        endfunction

        function void rub_out();
            line_len--;
            echo(tld_pkg::CH_BS);
            echo(tld_pkg::CH_SP);
            echo(tld_pkg::CH_BS);
        endfunction

        function int commit_line();
            int took;
            took = 0;
            while (took < line_len && push_in(line_buf[took])) took++;
            commit_line = line_len - took;
            line_len = 0;
        endfunction

        function void note_request(logic [1:0] op, logic [7:0] c);
            t_tty_result r;
            int lost;
            r = '0;
            lost = 0;
            requests_seen++;
            case (op)
                tld_pkg::OP_MASTER_WRITE: begin
                    r.accepted = 1;
                    if (sig_on && c == intr_ch) begin
                        line_len = 0;
                        echo(tld_pkg::CH_CARET);
                        echo(tld_pkg::CH_C);
                        echo(tld_pkg::CH_NL);
                        r.raise_interrupt = target_on;
                    end else if (!canon) begin
                        r.accepted = push_in(c);
                        if (r.accepted) echo(c);
                    end else if (c == erase_ch || c == tld_pkg::CH_DEL) begin
                        if (line_len > 0) rub_out();
                    end else if (c == kill_ch) begin
                        while (line_len > 0) rub_out();
                    end else if (c == eof_ch) begin
                        if (line_len == 0) eof_flag = 1;
                        else lost = commit_line();
                    end else if (line_len >= LD - 1) begin
                        r.accepted = 0;
                    end else begin
                        echo(c);
                        line_buf[line_len] = c;
                        line_len++;
                        if (c == tld_pkg::CH_NL) lost = commit_line();
                    end
                end
                tld_pkg::OP_SLAVE_WRITE: r.accepted = push_out(c);
                tld_pkg::OP_SLAVE_READ: begin
                    if (in_count() > 0) begin
                        r.read_byte = in_ring[in_tail];
                        in_tail = (in_tail + 1) % RD;
                        r.read_status = tld_pkg::ST_DATA;
                    end else if (eof_flag) begin
                        eof_flag = 0;
                        r.read_status = tld_pkg::ST_EOF;
                    end else begin
                        r.read_status = tld_pkg::ST_EMPTY;
                    end
                end
                default: begin
                    if (out_count() > 0) begin
                        r.read_byte = out_ring[out_tail];
                        out_tail = (out_tail + 1) % RD;
                        r.read_status = tld_pkg::ST_DATA;
                    end else begin
                        r.read_status = tld_pkg::ST_EMPTY;
                    end
                end
            endcase
            r.lost_bytes = (lost > 1023) ? 10'd1023 : lost[9:0];
            r.slave_readable = (in_count() > 0) || eof_flag;
            r.master_readable = out_count() > 0;
            r.master_writable = canon ? (line_len < LD - 1) : (in_count() < RD - 1);
            r.slave_writable = out_count() < RD - 1;
            pending.push_back(r);
        endfunction

        function void check_result(logic [23:0] tdata, logic [1:0] tuser);
            t_tty_result got, want;
            got.accepted = tdata[0];
            got.read_byte = tdata[8:1];
            got.raise_interrupt = tdata[9];
            got.lost_bytes = tdata[19:10];
            got.slave_readable = tdata[20];
            got.master_readable = tdata[21];
            got.master_writable = tdata[22];
            got.slave_writable = tdata[23];
            got.read_status = tuser;
            results_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result tdata=%h tuser=%h", tdata, tuser);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch #%0d: exp acc=%b byte=%h st=%0d int=%b lost=%0d fl=%b%b%b%b",
                             results_seen, want.accepted, want.read_byte, want.read_status,
                             want.raise_interrupt, want.lost_bytes, want.slave_readable,
                             want.master_readable, want.master_writable, want.slave_writable,
                             "\n             got acc=%b byte=%h st=%0d int=%b lost=%0d fl=%b%b%b%b",
                             got.accepted, got.read_byte, got.read_status,
                             got.raise_interrupt, got.lost_bytes, got.slave_readable,
                             got.master_readable, got.master_writable, got.slave_writable);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_tvalid = 0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 0;
    logic [23:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        i_psel = 0;
    logic        i_penable = 0;
    logic        i_pwrite = 0;
    logic [tld_pkg::CFG_AW-1:0] i_paddr = '0;
    logic [31:0] i_pwdata = '0;
    logic [31:0] o_prdata;
    logic        o_pready;

    terminal_line_discipline uut (.*);

    always #1 i_clk = ~i_clk;

    tty_scoreboard sb = new();
    bit idle_allowed = 1;
    int quiet_cycles = 0;
    int phases_run = 0;
    bit timed_out = 0;

    localparam int QUIET_LIMIT = 60000;

    always @(negedge i_clk)
        i_m_tready <= !(idle_allowed && $urandom_range(99) < 7);

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tuser);
        if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] op, logic [7:0] c);
        while (idle_allowed && $urandom_range(99) < 7) begin
            i_s_tvalid <= 0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser <= op;
        i_s_tdata <= c;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(op, c);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_psel <= 1;
        i_penable <= 0;
        i_pwrite <= 1;
        i_paddr <= (tld_pkg::CFG_AW)'(idx) << 2;
        i_pwdata <= val;
        @(negedge i_clk);
        i_penable <= 1;
        do @(posedge i_clk); while (!o_pready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_psel <= 0;
        i_penable <= 0;
    endtask

    task automatic configure(bit canon, bit echo_on, bit sig_on, logic [7:0] intr_ch,
                             logic [7:0] eof_ch, logic [7:0] erase_ch, logic [7:0] kill_ch,
                             bit target_on);
        drain();
        write_reg(tld_pkg::REG_CANON, ({$urandom} & 32'hFFFF_FFFE) | 32'(canon));
        write_reg(tld_pkg::REG_ECHO, 32'(echo_on));
        write_reg(tld_pkg::REG_SIG, 32'(sig_on));
        write_reg(tld_pkg::REG_INTR, 32'(intr_ch));
        write_reg(tld_pkg::REG_EOF, 32'(eof_ch));
        write_reg(tld_pkg::REG_ERASE, 32'(erase_ch));
        write_reg(tld_pkg::REG_KILL, 32'(kill_ch));
        write_reg(tld_pkg::REG_TARGET, 32'(target_on));
        phases_run++;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return sb.intr_ch;
            1: return sb.eof_ch;
            2: return sb.erase_ch;
            3: return tld_pkg::CH_DEL;
            4: return sb.kill_ch;
            5: return tld_pkg::CH_NL;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic random_traffic(int n);
        int left, len;
        left = n;
        while (left > 0) begin
            if ($urandom_range(99) < 55) begin
                len = $urandom_range(14, 1);
                repeat (len) send_request(tld_pkg::OP_MASTER_WRITE, 8'($urandom_range(126, 32)));
                if ($urandom_range(3) == 0) send_request(tld_pkg::OP_MASTER_WRITE, sb.erase_ch);
                send_request(tld_pkg::OP_MASTER_WRITE,
                             $urandom_range(1) ? tld_pkg::CH_NL : sb.eof_ch);
                repeat ($urandom_range(len + 2)) send_request(tld_pkg::OP_SLAVE_READ, 8'($urandom));
                repeat ($urandom_range(6)) send_request(tld_pkg::OP_MASTER_READ, 8'($urandom));
                left -= len + 4;
            end else begin
                send_request(2'($urandom_range(3)), pick_byte());
                left--;
            end
        end
    endtask

    initial begin
        sb.init();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed checks at reset settings
        send_request(tld_pkg::OP_SLAVE_READ, 8'h00);
        send_request(tld_pkg::OP_MASTER_READ, 8'hFF);
        send_request(tld_pkg::OP_MASTER_WRITE, 8'h04);
        send_request(tld_pkg::OP_SLAVE_READ, 8'h00);
        send_request(tld_pkg::OP_MASTER_WRITE, 8'h08);
        send_request(tld_pkg::OP_MASTER_WRITE, 8'h41);
        send_request(tld_pkg::OP_MASTER_WRITE, 8'h7F);
        send_request(tld_pkg::OP_MASTER_WRITE, 8'hFF);
        send_request(tld_pkg::OP_MASTER_WRITE, 8'h00);
        send_request(tld_pkg::OP_MASTER_WRITE, 8'h15);
        send_request(tld_pkg::OP_MASTER_WRITE, 8'h62);
        send_request(tld_pkg::OP_MASTER_WRITE, 8'h03);
        send_request(tld_pkg::OP_MASTER_WRITE, 8'h63);
        send_request(tld_pkg::OP_MASTER_WRITE, 8'h04);
        send_request(tld_pkg::OP_MASTER_WRITE, 8'h0A);
        send_request(tld_pkg::OP_SLAVE_WRITE, 8'hFF);
        send_request(tld_pkg::OP_SLAVE_WRITE, 8'h00);
        repeat (3) send_request(tld_pkg::OP_SLAVE_READ, 8'hFF);
        repeat (5) send_request(tld_pkg::OP_MASTER_READ, 8'h00);

        idle_allowed = 0;
        random_traffic(100);
        idle_allowed = 1;
        random_traffic(80);

        configure(0, 1, 1, 8'd3, 8'd4, 8'd8, 8'd21, 0);
        random_traffic(60);
        configure(1, 0, 0, 8'd0, 8'd255, 8'd0, 8'd255, 1);
        random_traffic(60);
        configure(1, 1, 1, 8'd255, 8'd0, 8'd255, 8'd0, 0);
        random_traffic(60);
        configure(1, 1, 1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1);
        random_traffic(60);

        // fill the line, commit it into the input ring while echoes fill the output ring
        configure(1, 1, 1, 8'd3, 8'd4, 8'd8, 8'd21, 1);
        repeat (1024) send_request(tld_pkg::OP_MASTER_WRITE, 8'($urandom_range(126, 32)));
        send_request(tld_pkg::OP_MASTER_WRITE, 8'd4);
        repeat (2) send_request(tld_pkg::OP_SLAVE_WRITE, 8'($urandom));
        repeat (4) send_request(tld_pkg::OP_MASTER_WRITE, 8'($urandom_range(126, 32)));
        send_request(tld_pkg::OP_MASTER_WRITE, tld_pkg::CH_NL);
        configure(0, 1, 1, 8'd3, 8'd4, 8'd8, 8'd21, 1);
        repeat (3) send_request(tld_pkg::OP_MASTER_WRITE, 8'($urandom));
        configure(1, 1, 1, 8'd3, 8'd4, 8'd8, 8'd21, 1);
        repeat (30) send_request(tld_pkg::OP_MASTER_WRITE, 8'($urandom_range(126, 32)));
        send_request(tld_pkg::OP_MASTER_WRITE, 8'd21);
        repeat (20) send_request(tld_pkg::OP_SLAVE_READ, 8'h00);
        repeat (20) send_request(tld_pkg::OP_MASTER_READ, 8'h00);

        drain();
        $display("covered %0d requests and %0d results over %0d register settings",
                 sb.requests_seen, sb.results_seen, phases_run + 1);
        $display("edit, interrupt, end-of-file, raw and full-ring cases; %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+design
design/tld_pkg.sv
design/terminal_line_discipline.sv
bench/tb.sv
